@@ design/spiadc_pkg.sv @@
`timescale 1ns / 1ps
// spiadc_pkg: types and constants for the serial converter sample sequencer.
// No dependencies; used by spi_adc_sample_sequencer_top.
package spiadc_pkg;

    localparam int SAMPLE_BITS = 16;
    localparam int BIT_CNT_W   = $clog2(SAMPLE_BITS + 1);
    localparam int CFG_DATA_W  = 16;
    localparam int CFG_INDEX_W = 2;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_SAMPLE_COUNT = 2'd0,
        CFG_GAP_TICKS    = 2'd1,
        CFG_HALF_PERIOD  = 2'd2,
        CFG_CONV_TICKS   = 2'd3
    } cfg_index_t;

    typedef enum logic [2:0] {
        PH_IDLE     = 3'd0,
        PH_PULSE    = 3'd1,
        PH_CONV     = 3'd2,
        PH_DUMMY_HI = 3'd3,
        PH_DUMMY_LO = 3'd4,
        PH_BIT_HI   = 3'd5,
        PH_BIT_LO   = 3'd6,
        PH_GAP      = 3'd7
    } phase_t;

    typedef struct packed {
        logic        cnv_level;
        logic        sck_level;
        logic        sdi_level;
        logic        sample_valid;
        logic [15:0] sample_value;
        logic [15:0] sample_index;
        logic        busy_res;
        logic        done_res;
        logic        success;
        logic [15:0] samples_taken;
    } res_t;

endpackage

@@ design/spi_adc_sample_sequencer_top.sv @@
`timescale 1ns / 1ps
// spi_adc_sample_sequencer_top: pin-level sequencer for a serial converter.
// Depends on spiadc_pkg.
//
// Each input word is one timing tick (start request and the SDO level) and yields exactly one
// output word with the pin levels and status for that tick. The sequencer takes one word per
// clock cycle while in_stall is low; each result is registered in the output register, or in a
// second result stage that accepts one more word while a result waits downstream. The
// phase/counter update is combinational. The user must write the configuration registers through
// cfg_en/cfg_index/cfg_data only while idle; the block itself does not enforce this.
module spi_adc_sample_sequencer_top
(
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_en,
    input  logic [spiadc_pkg::CFG_INDEX_W-1:0]  cfg_index,
    input  logic [spiadc_pkg::CFG_DATA_W-1:0]   cfg_data,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic                                start_req,
    input  logic                                sdo_level,
    output logic                                out_valid,
    input  logic                                out_stall,
    output logic                                cnv_level,
    output logic                                sck_level,
    output logic                                sdi_level,
    output logic                                sample_valid,
    output logic [15:0]                         sample_value,
    output logic [15:0]                         sample_index,
    output logic                                busy_res,
    output logic                                done_res,
    output logic                                success,
    output logic [15:0]                         samples_taken
);

    logic [15:0] sample_count_reg;
    logic [15:0] gap_ticks_reg;
    logic [7:0]  half_period_reg;
    logic [7:0]  conv_ticks_reg;

    spiadc_pkg::phase_t                     phase_reg, phase_next;
    logic [15:0]                            tick_reg, tick_next;
    logic [spiadc_pkg::BIT_CNT_W-1:0]       bit_cnt_reg, bit_cnt_next;
    logic [15:0]                            smp_cnt_reg, smp_cnt_next;
    logic [spiadc_pkg::SAMPLE_BITS-1:0]     shift_reg, shift_next;
    logic                                   ok_reg, ok_next;

    spiadc_pkg::res_t res;
    spiadc_pkg::res_t out_word_reg;
    spiadc_pkg::res_t skid_word_reg;
    logic             out_valid_reg;
    logic             skid_valid_reg;

    logic                              in_fire;
    logic                              out_free;
    logic                              tick_zero;
    logic                              run_start;
    logic                              last_bit;
    logic                              count_done;
    logic [spiadc_pkg::BIT_CNT_W-1:0]  bit_inc;
    logic [15:0]                       half_m1;
    logic [15:0]                       conv_m1;
    logic [spiadc_pkg::SAMPLE_BITS-1:0] shift_in;

    assign in_stall  = skid_valid_reg;
    assign in_fire   = in_valid && !skid_valid_reg;
    assign out_free  = !out_valid_reg || !out_stall;

    assign tick_zero  = (tick_reg == 16'd0);
    assign run_start  = start_req && (sample_count_reg != 16'd0);
    assign bit_inc    = bit_cnt_reg + 1'b1;
    assign last_bit   = (bit_inc >= spiadc_pkg::BIT_CNT_W'(spiadc_pkg::SAMPLE_BITS));
    assign count_done = (smp_cnt_reg >= sample_count_reg);
    assign half_m1    = (half_period_reg == 8'd0) ? 16'd0 : {8'd0, half_period_reg - 8'd1};
    assign conv_m1    = (conv_ticks_reg == 8'd0) ? 16'd0 : {8'd0, conv_ticks_reg - 8'd1};
    assign shift_in   = {shift_reg[spiadc_pkg::SAMPLE_BITS-2:0], sdo_level};

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        unique case (phase_reg)
            spiadc_pkg::PH_IDLE:
            begin
                if (run_start)
                    phase_next = spiadc_pkg::PH_PULSE;
            end
            spiadc_pkg::PH_PULSE:    phase_next = spiadc_pkg::PH_CONV;
            spiadc_pkg::PH_CONV:
            begin
                if (tick_zero)
                    phase_next = sdo_level ? spiadc_pkg::PH_IDLE : spiadc_pkg::PH_DUMMY_HI;
            end
            spiadc_pkg::PH_DUMMY_HI: phase_next = spiadc_pkg::PH_DUMMY_LO;
            spiadc_pkg::PH_DUMMY_LO: phase_next = spiadc_pkg::PH_BIT_HI;
            spiadc_pkg::PH_BIT_HI:
            begin
                if (tick_zero)
                    phase_next = spiadc_pkg::PH_BIT_LO;
            end
            spiadc_pkg::PH_BIT_LO:
            begin
                if (tick_zero)
                    phase_next = last_bit ? spiadc_pkg::PH_GAP : spiadc_pkg::PH_BIT_HI;
            end
            spiadc_pkg::PH_GAP:
            begin
                if (tick_zero)
                    phase_next = count_done ? spiadc_pkg::PH_IDLE : spiadc_pkg::PH_PULSE;
            end
            default: phase_next = spiadc_pkg::PH_IDLE;
        endcase
    end

    // counters, shift word and output word
    always_comb
    begin
        tick_next         = tick_reg;
        bit_cnt_next      = bit_cnt_reg;
        smp_cnt_next      = smp_cnt_reg;
        shift_next        = shift_reg;
        ok_next           = ok_reg;
        // pin levels for the tick, from the phase entered
        res.cnv_level     = (phase_next != spiadc_pkg::PH_IDLE) &&
                            (phase_next != spiadc_pkg::PH_GAP);
        res.sck_level     = (phase_next == spiadc_pkg::PH_DUMMY_HI) ||
                            (phase_next == spiadc_pkg::PH_BIT_HI);
        res.sdi_level     = (phase_next == spiadc_pkg::PH_PULSE);
        res.busy_res      = (phase_next != spiadc_pkg::PH_IDLE);
        res.sample_valid  = 1'b0;
        res.sample_value  = 16'd0;
        res.sample_index  = 16'd0;
        res.done_res      = 1'b0;
        res.success       = 1'b0;
        res.samples_taken = 16'd0;
        unique case (phase_reg)
            spiadc_pkg::PH_IDLE:
            begin
                if (start_req)
                begin
                    if (sample_count_reg == 16'd0)
                        res.done_res = 1'b1;
                    else
                    begin
                        smp_cnt_next = 16'd0;
                        ok_next      = 1'b0;
                        shift_next   = '0;
                    end
                end
            end
            spiadc_pkg::PH_PULSE:
            begin
                tick_next = conv_m1;
            end
            spiadc_pkg::PH_CONV:
            begin
                if (!tick_zero)
                    tick_next = tick_reg - 16'd1;
                else if (sdo_level)
                begin
                    res.done_res      = 1'b1;
                    res.samples_taken = smp_cnt_reg;
                end
            end
            spiadc_pkg::PH_DUMMY_HI:
            begin
            end
            spiadc_pkg::PH_DUMMY_LO:
            begin
                bit_cnt_next = '0;
                shift_next   = shift_in;
                tick_next    = half_m1;
            end
            spiadc_pkg::PH_BIT_HI:
            begin
                tick_next = tick_zero ? half_m1 : tick_reg - 16'd1;
            end
            spiadc_pkg::PH_BIT_LO:
            begin
                if (!tick_zero)
                    tick_next = tick_reg - 16'd1;
                else
                begin
                    bit_cnt_next = bit_inc;
                    if (!last_bit)
                    begin
                        shift_next = shift_in;
                        tick_next  = half_m1;
                    end
                    else
                    begin
                        res.sample_valid = 1'b1;
                        res.sample_value = 16'(shift_reg);
                        res.sample_index = smp_cnt_reg;
                        smp_cnt_next     = smp_cnt_reg + 16'd1;
                        ok_next          = 1'b1;
                        tick_next        = gap_ticks_reg;
                    end
                end
            end
            spiadc_pkg::PH_GAP:
            begin
                if (!tick_zero)
                    tick_next = tick_reg - 16'd1;
                else if (count_done)
                begin
                    res.done_res      = 1'b1;
                    res.success       = ok_reg;
                    res.samples_taken = smp_cnt_reg;
                end
                else
                    shift_next = '0;
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_count_reg <= 16'd0;
            gap_ticks_reg    <= 16'd0;
            half_period_reg  <= 8'd2;
            conv_ticks_reg   <= 8'd2;
        end
        else if (cfg_en)
        begin
            unique case (spiadc_pkg::cfg_index_t'(cfg_index))
                spiadc_pkg::CFG_SAMPLE_COUNT: sample_count_reg <= cfg_data;
                spiadc_pkg::CFG_GAP_TICKS:    gap_ticks_reg    <= cfg_data;
                spiadc_pkg::CFG_HALF_PERIOD:  half_period_reg  <= cfg_data[7:0];
                spiadc_pkg::CFG_CONV_TICKS:   conv_ticks_reg   <= cfg_data[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg   <= spiadc_pkg::PH_IDLE;
            tick_reg    <= 16'd0;
            bit_cnt_reg <= '0;
            smp_cnt_reg <= 16'd0;
            shift_reg   <= '0;
            ok_reg      <= 1'b0;
        end
        else if (in_fire)
        begin
            phase_reg   <= phase_next;
            tick_reg    <= tick_next;
            bit_cnt_reg <= bit_cnt_next;
            smp_cnt_reg <= smp_cnt_next;
            shift_reg   <= shift_next;
            ok_reg      <= ok_next;
        end
    end

    // output register plus skid stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (out_free)
                out_valid_reg <= skid_valid_reg || in_fire;
            if (skid_valid_reg)
            begin
                if (out_valid_reg && !out_stall)
                    skid_valid_reg <= 1'b0;
            end
            else if (in_fire && !out_free)
                skid_valid_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_free)
        begin
            if (skid_valid_reg)
                out_word_reg <= skid_word_reg;
            else if (in_fire)
                out_word_reg <= res;
        end
        if (in_fire && !out_free)
            skid_word_reg <= res;
    end

    assign out_valid     = out_valid_reg;
    assign cnv_level     = out_word_reg.cnv_level;
    assign sck_level     = out_word_reg.sck_level;
    assign sdi_level     = out_word_reg.sdi_level;
    assign sample_valid  = out_word_reg.sample_valid;
    assign sample_value  = out_word_reg.sample_value;
    assign sample_index  = out_word_reg.sample_index;
    assign busy_res      = out_word_reg.busy_res;
    assign done_res      = out_word_reg.done_res;
    assign success       = out_word_reg.success;
    assign samples_taken = out_word_reg.samples_taken;

endmodule

@@ design/spiadc_checker.sv @@
`timescale 1ns / 1ps
// spiadc_checker: port-level assertions for spi_adc_sample_sequencer_top.
// Bound to the top level below; no package dependency.
module spiadc_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        out_valid,
    input logic        out_stall,
    input logic        cnv_level,
    input logic        sck_level,
    input logic        sdi_level,
    input logic        sample_valid,
    input logic [15:0] sample_value,
    input logic        busy_res,
    input logic        done_res
);

    a_done_not_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && done_res |-> !busy_res)
        else $error("done word still shows busy");

    a_sample_in_gap: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sample_valid |-> busy_res && !cnv_level && !sck_level && !done_res)
        else $error("sample word with pins active or run ended");

    a_sck_needs_cnv: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sck_level |-> cnv_level && busy_res)
        else $error("serial clock high without convert");

    a_sdi_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && sdi_level |-> cnv_level && !sck_level)
        else $error("data-in pulse outside convert start");

    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(sample_value) && $stable(done_res))
        else $error("stalled output word changed");

endmodule

bind spi_adc_sample_sequencer_top spiadc_checker u_spiadc_checker
(
    .clk          (clk),
    .rst_n        (rst_n),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .cnv_level    (cnv_level),
    .sck_level    (sck_level),
    .sdi_level    (sdi_level),
    .sample_valid (sample_valid),
    .sample_value (sample_value),
    .busy_res     (busy_res),
    .done_res     (done_res)
);
